// ===== design/mi_matrix_dpi_pruner_unit_macros.svh =====
// Assertion shorthands shared by the pruner's RTL.
// Every check is sampled on the rising clock edge and is switched off while reset is high.
`ifndef MI_MATRIX_DPI_PRUNER_UNIT_MACROS_SVH
`define MI_MATRIX_DPI_PRUNER_UNIT_MACROS_SVH

// The condition holds at every clock edge.
`define MMDP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MMDP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/mmdp_pkg.sv =====
package mmdp_pkg;

  // Default sizes of the matrix store.
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 256;
  localparam int VALUE_BITS_DEF = 24;

  // Field widths of the stream items.
  localparam int KIND_W     = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 8;
  localparam int ENTRY_W    = 24;
  localparam int IN_DATA_W  = 40;
  localparam int READ_W     = 24;
  localparam int COUNT_W    = 15;
  localparam int OUT_DATA_W = 40;

  // Configuration registers.
  localparam int ROWS_REG_W = 7;
  localparam int COLS_REG_W = 9;
  localparam int TOL_W      = 23;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 9'd256;
  localparam logic [TOL_W-1:0]      TOL_RESET  = 23'd0;

  // Result queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_TOL  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MIJ,
    S_MIJ_CHK,
    S_KSEL,
    S_IK,
    S_KI,
    S_KJ,
    S_JK,
    S_DRAIN,
    S_CMP,
    S_NEXTJ,
    S_DONE
  } seq_state_t;

  // What the memory returns in the cycle after a read was issued.
  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_MIJ,
    TAG_IK,
    TAG_KI,
    TAG_KJ,
    TAG_JK,
    TAG_READ,
    TAG_ZERO
  } rd_tag_t;

  typedef struct packed {
    logic               is_pass_done;
    logic [COUNT_W-1:0] pruned_count;
    logic [READ_W-1:0]  read_value;
  } result_t;

endpackage

// ===== design/mi_matrix_dpi_pruner_unit.sv =====
// Mutual-information pruner. The block holds a regulator-by-gene matrix of signed fixed-point
// entries (16 fraction bits) in one single-port-read memory and takes three kinds of item on its
// input stream: a write item stores one entry and gives no result, a read item returns one entry,
// and a start item runs the data processing inequality pass over the active matrix in row-major
// order and returns the number of entries it zeroed. Write and read items are taken one per clock
// cycle while the block is idle and the result queue has room; a read result comes back from the
// registered memory read and waits in a four-item result queue, so the input side keeps moving
// while the output side stalls, until the queue is full. A start item holds the input off until
// its pass is complete. The pass is paced by the single read port of the matrix memory, which one
// small sequencer shares for every operand: each visited entry takes a read step, a check step
// and a step to advance, each mediator takes a selection step, and each mediator that is actually
// tested adds one memory read per operand that exists, a step to land the last read and one to
// compare; the pass ends in a state that posts the result. The memory is not cleared after reset;
// reading an entry that was never written gives an unspecified value.
// Configuration goes through the APB port at byte addresses 0 (regulator rows), 4 (gene columns)
// and 8 (tolerance), and is meant to be written only while the block is idle.
`include "mi_matrix_dpi_pruner_unit_macros.svh"

module mi_matrix_dpi_pruner_unit #(
  parameter int MAX_ROWS   = mmdp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = mmdp_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = mmdp_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Bits from the lowest up: row [5:0], col [13:6], entry_value [37:14], zero padding.
  input  logic [mmdp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Bits from the lowest up: kind [1:0].
  input  logic [mmdp_pkg::KIND_W-1:0]     s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Bits from the lowest up: read_value [23:0], pruned_count [38:24], zero padding.
  output logic [mmdp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Bits from the lowest up: is_pass_done [0].
  output logic                            m_axis_tuser,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmdp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mmdp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mmdp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  import mmdp_pkg::*;

  // Counters must hold the column count, the row limit and the 9-bit register value.
  localparam int CW_COLS = $clog2(MAX_COLS + 1);
  localparam int CW_ROWS = $clog2(MAX_ROWS + 1);
  localparam int CW_MAX  = (CW_COLS > CW_ROWS) ? CW_COLS : CW_ROWS;
  localparam int CNT_W   = (CW_MAX > COLS_REG_W) ? CW_MAX : COLS_REG_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  // The tolerance-shifted entry needs room for either operand plus a carry and a sign.
  localparam int SUM_W   = ((VALUE_BITS > TOL_W) ? VALUE_BITS : TOL_W) + 2;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
    addr_of = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // Configuration registers.
  logic [ROWS_REG_W-1:0] regulator_rows;
  logic [COLS_REG_W-1:0] gene_columns;
  logic [TOL_W-1:0]      prune_tolerance;
  logic                  cfg_write;
  cfg_reg_t              cfg_sel;

  // Sequencer.
  seq_state_t state, state_next;
  rd_tag_t    cap_tag, cap_tag_next;
  logic [CNT_W-1:0] idx_i, idx_j, idx_k;
  logic [CNT_W-1:0] cols_act, rows_lim, rows_act;
  logic [COUNT_W-1:0] pruned;
  logic signed [VALUE_BITS-1:0] mik, mkj, lower;
  logic signed [SUM_W-1:0]      mij_tol;
  logic prune_hit;
  logic last_col, last_row;

  // Memory ports.
  logic                  ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_wr_data, ram_rd_data;
  logic signed [VALUE_BITS-1:0] rd_val;

  // Input item decode.
  logic                in_fire;
  kind_t               in_kind;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic [ENTRY_W-1:0]  in_value;
  logic                in_inside;

  // Result queue.
  result_t              res_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  push_en, pop;
  result_t               push_data, head;
  logic                  read_pend;

  // ---------------------------------------------------------------------------------------------
  // Configuration port. Registers sit on word addresses; the register index is paddr[3:2].
  // ---------------------------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regulator_rows  <= ROWS_RESET;
      gene_columns    <= COLS_RESET;
      prune_tolerance <= TOL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_ROWS: regulator_rows  <= pwdata[ROWS_REG_W-1:0];
        REG_COLS: gene_columns    <= pwdata[COLS_REG_W-1:0];
        REG_TOL:  prune_tolerance <= pwdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_ROWS: prdata = APB_DATA_W'(regulator_rows);
      REG_COLS: prdata = APB_DATA_W'(gene_columns);
      REG_TOL:  prdata = APB_DATA_W'(prune_tolerance);
      default:  prdata = '0;
    endcase
  end

  // Active sizes: columns are capped by the store, rows by the store and by the columns.
  assign cols_act = (CNT_W'(gene_columns) < CNT_W'(MAX_COLS)) ? CNT_W'(gene_columns)
                                                               : CNT_W'(MAX_COLS);
  assign rows_lim = (CNT_W'(regulator_rows) < CNT_W'(MAX_ROWS)) ? CNT_W'(regulator_rows)
                                                                 : CNT_W'(MAX_ROWS);
  assign rows_act = (rows_lim < cols_act) ? rows_lim : cols_act;

  // ---------------------------------------------------------------------------------------------
  // Input decode. The block only listens while idle, and only while the result queue has room
  // for every read that could still land in it.
  // ---------------------------------------------------------------------------------------------
  assign in_kind   = kind_t'(s_axis_tuser);
  assign in_row    = s_axis_tdata[ROW_W-1:0];
  assign in_col    = s_axis_tdata[ROW_W +: COL_W];
  assign in_value  = s_axis_tdata[ROW_W + COL_W +: ENTRY_W];
  assign in_inside = (CNT_W'(in_row) < CNT_W'(MAX_ROWS)) && (CNT_W'(in_col) < CNT_W'(MAX_COLS));

  assign read_pend     = (cap_tag == TAG_READ) || (cap_tag == TAG_ZERO);
  assign s_axis_tready = (state == S_IDLE) &&
                         ((fifo_cnt + FIFO_CNT_W'(read_pend)) < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------------------------
  // Pruning sequencer. One memory read is issued per cycle at most; its data is picked up in
  // the following cycle according to the tag that travels with it.
  // ---------------------------------------------------------------------------------------------
  assign rd_val    = signed'(ram_rd_data);
  assign lower     = (mik < mkj) ? mik : mkj;
  assign prune_hit = mij_tol < SUM_W'(lower);
  assign last_col  = (idx_j + CNT_W'(1)) == cols_act;
  assign last_row  = (idx_i + CNT_W'(1)) == rows_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cap_tag <= TAG_NONE;
    end else begin
      state   <= state_next;
      cap_tag <= cap_tag_next;
    end
  end

  always_comb begin
    state_next   = state;
    cap_tag_next = TAG_NONE;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_WRITE: begin
              ram_wr_en   = in_inside;
              ram_wr_addr = addr_of(CNT_W'(in_row), CNT_W'(in_col));
              ram_wr_data = VALUE_BITS'(signed'(in_value));
            end
            KIND_START: begin
              state_next = (rows_act == '0) ? S_DONE : S_MIJ;
            end
            KIND_READ: begin
              // A read outside the store answers zero without touching the memory.
              ram_rd_en    = in_inside;
              ram_rd_addr  = addr_of(CNT_W'(in_row), CNT_W'(in_col));
              cap_tag_next = in_inside ? TAG_READ : TAG_ZERO;
            end
            default: begin
            end
          endcase
        end
      end
      S_MIJ: begin
        ram_rd_en    = 1'b1;
        ram_rd_addr  = addr_of(idx_i, idx_j);
        cap_tag_next = TAG_MIJ;
        state_next   = S_MIJ_CHK;
      end
      S_MIJ_CHK: begin
        // Entries at or below zero are left alone.
        state_next = (rd_val <= 0) ? S_NEXTJ : S_KSEL;
      end
      S_KSEL: begin
        if (idx_k == cols_act) begin
          state_next = S_NEXTJ;
        end else if ((idx_k != idx_i) && (idx_k != idx_j)) begin
          state_next = S_IK;
        end
      end
      S_IK: begin
        ram_rd_en    = 1'b1;
        ram_rd_addr  = addr_of(idx_i, idx_k);
        cap_tag_next = TAG_IK;
        if (idx_k < rows_act) begin
          state_next = S_KI;
        end else if (idx_j < rows_act) begin
          state_next = S_JK;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_KI: begin
        ram_rd_en    = 1'b1;
        ram_rd_addr  = addr_of(idx_k, idx_i);
        cap_tag_next = TAG_KI;
        state_next   = S_KJ;
      end
      S_KJ: begin
        ram_rd_en    = 1'b1;
        ram_rd_addr  = addr_of(idx_k, idx_j);
        cap_tag_next = TAG_KJ;
        state_next   = (idx_j < rows_act) ? S_JK : S_DRAIN;
      end
      S_JK: begin
        ram_rd_en    = 1'b1;
        ram_rd_addr  = addr_of(idx_j, idx_k);
        cap_tag_next = TAG_JK;
        state_next   = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (prune_hit) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = addr_of(idx_i, idx_j);
          ram_wr_data = '0;
          state_next  = S_NEXTJ;
        end else begin
          state_next = S_KSEL;
        end
      end
      S_NEXTJ: begin
        state_next = (last_col && last_row) ? S_DONE : S_MIJ;
      end
      S_DONE: begin
        if (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The pass count doubles as the stored tally of the last pass, so it is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pruned <= '0;
    end else if ((state == S_IDLE) && in_fire && (in_kind == KIND_START)) begin
      pruned <= '0;
    end else if ((state == S_CMP) && prune_hit) begin
      pruned <= pruned + COUNT_W'(1);
    end
  end

  // Loop indices and the running operand maxima.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx_i <= '0;
        idx_j <= '0;
      end
      S_MIJ_CHK: begin
        idx_k <= '0;
      end
      S_KSEL: begin
        if ((idx_k != cols_act) && ((idx_k == idx_i) || (idx_k == idx_j))) begin
          idx_k <= idx_k + CNT_W'(1);
        end
      end
      S_IK: begin
        mik <= '0;
        mkj <= '0;
      end
      S_CMP: begin
        if (!prune_hit) begin
          idx_k <= idx_k + CNT_W'(1);
        end
      end
      S_NEXTJ: begin
        if (last_col) begin
          idx_j <= '0;
          idx_i <= idx_i + CNT_W'(1);
        end else begin
          idx_j <= idx_j + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    // Read data lands in the cycle after issue; no read is in flight while the maxima are cleared.
    unique case (cap_tag)
      TAG_MIJ: begin
        mij_tol <= SUM_W'(rd_val) + SUM_W'(prune_tolerance);
      end
      TAG_IK, TAG_KI: begin
        if (rd_val > mik) begin
          mik <= rd_val;
        end
      end
      TAG_KJ, TAG_JK: begin
        if (rd_val > mkj) begin
          mkj <= rd_val;
        end
      end
      default: begin
      end
    endcase
  end

  mmdp_ram #(
    .WIDTH  (VALUE_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------------------------------
  // Result queue. Read results enter as their data returns; the pass result enters from the
  // final state. The two never fall in the same cycle.
  // ---------------------------------------------------------------------------------------------
  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    if (cap_tag == TAG_READ) begin
      push_en              = 1'b1;
      push_data.read_value = READ_W'(rd_val);
    end else if (cap_tag == TAG_ZERO) begin
      push_en = 1'b1;
    end else if ((state == S_DONE) && (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH))) begin
      push_en                = 1'b1;
      push_data.is_pass_done = 1'b1;
      push_data.pruned_count = pruned;
    end
  end

  assign head          = res_q[rd_ptr];
  assign m_axis_tvalid = fifo_cnt != '0;
  assign m_axis_tdata  = OUT_DATA_W'({head.pruned_count, head.read_value});
  assign m_axis_tuser  = head.is_pass_done;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + FIFO_CNT_W'(push_en) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      res_q[wr_ptr] <= push_data;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------------
  `MMDP_ASSERT_ALWAYS(a_fifo_bound, fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH), "result queue over depth")
  `MMDP_ASSERT_IMPLY(a_push_room, push_en, (fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || pop, "push into a full queue")
  `MMDP_ASSERT_IMPLY(a_no_read_in_pass, state == S_KSEL, !read_pend, "read item data during a pass")
  `MMDP_ASSERT_IMPLY(a_index_bound, state == S_MIJ, (idx_i < rows_act) && (idx_j < cols_act), "pass index outside active matrix")

endmodule

// ===== design/mmdp_ram.sv =====
module mmdp_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
